// File: rtl/core/hpg_pkg.sv
// ============================================================================
// Hammersley point generator package
// Widths, reset values and the radix-2 divider step shared by the core.
// ============================================================================
package hpg_pkg;

  localparam int CNT_W      = 17;  // row sample count
  localparam int ROW_W      = 2;   // row select
  localparam int IDX_IN_W   = 16;  // sample index port
  localparam int FRAC_W     = 24;  // first coordinate fraction
  localparam int RADINV_W   = 32;  // second coordinate fraction
  localparam int CFG_IDX_W  = 2;   // configuration register index

  // Quotient bits resolved per divider stage, and the resulting stage count.
  localparam int STAGE_BITS = 2;
  localparam int DIV_STAGES = FRAC_W / STAGE_BITS;

  localparam logic [CNT_W-1:0] COUNT_RESET = 17'd64;

  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [FRAC_W-1:0]   frac_t;
  typedef logic [RADINV_W-1:0] radinv_t;

  typedef struct packed {
    logic q;
    cnt_t rem;
  } step_t;

  // One restoring division step. The partial remainder is always below the
  // divisor, so doubling it needs only one extra bit.
  function automatic step_t div_step(cnt_t rem, cnt_t cnt);
    logic [CNT_W:0] sh;
    logic [CNT_W:0] diff;
    step_t          res;
    sh   = {rem, 1'b0};
    diff = sh - {1'b0, cnt};
    if (sh >= {1'b0, cnt}) begin
      res.q   = 1'b1;
      res.rem = diff[CNT_W-1:0];
    end else begin
      res.q   = 1'b0;
      res.rem = sh[CNT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/hammersley_point_generator.sv
// ============================================================================
// Hammersley point generator
// One texel of a 2D Hammersley set per beat: index over row count as a 24-bit
// fraction and the base-2 radical inverse of the index.
// ============================================================================
// done_o rises once an accepted start_i has passed every pipeline register.
// Throughput: one item per cycle; the 24 quotient bits are resolved two per
// stage over a 12-stage divider pipeline, behind one input and one output
// register. busy_o stays low, as nothing downstream can hold results off.
// Reset empties the pipeline and sets every row count to 64.
module hammersley_point_generator #(
  parameter int INDEX_BITS = 16,
  parameter int ROW_COUNT  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [hpg_pkg::ROW_W-1:0]          row_select_i,
  input  logic [hpg_pkg::IDX_IN_W-1:0]       sample_index_i,
  input  logic                               cfg_we_i,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hpg_pkg::CNT_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic [hpg_pkg::FRAC_W-1:0]         first_coord_o,
  output logic [hpg_pkg::RADINV_W-1:0]       second_coord_o,
  output logic                               in_range_o
);
  import hpg_pkg::*;

  // Index bits that take part; the port holds at most IDX_IN_W of them.
  localparam int IDX_W = (INDEX_BITS < IDX_IN_W) ? INDEX_BITS : IDX_IN_W;

  // --------------------------------------------------------------------------
  // Row count registers
  // --------------------------------------------------------------------------
  cnt_t row_count_q [ROW_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_count_q[r] <= COUNT_RESET;
      end
    end else if (cfg_we_i) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        if (cfg_idx_i == CFG_IDX_W'(r)) begin
          row_count_q[r] <= cfg_wdata_i;
        end
      end
    end
  end

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Input stage: row lookup and range check
  // --------------------------------------------------------------------------
  cnt_t             sel_count;
  logic [IDX_W-1:0] idx_in;
  logic             rng_in;

  always_comb begin
    sel_count = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (row_select_i == ROW_W'(r)) begin
        sel_count = row_count_q[r];
      end
    end
  end

  assign idx_in = sample_index_i[IDX_W-1:0];
  assign rng_in = (CNT_W'(idx_in) < sel_count);

  // Pipeline registers; entry 0 is the input stage, entry DIV_STAGES the last
  // divider stage.
  logic             vld_q [DIV_STAGES+1];
  logic             rng_q [DIV_STAGES+1];
  cnt_t             cnt_q [DIV_STAGES+1];
  cnt_t             rem_q [DIV_STAGES+1];
  frac_t            quo_q [DIV_STAGES+1];
  logic [IDX_W-1:0] idx_q [DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
    end
  end

  // An out-of-range index never reaches the output, so its remainder only
  // has to stay below the count; zero keeps that true.
  always_ff @(posedge clk_i) begin
    rng_q[0] <= rng_in;
    cnt_q[0] <= sel_count;
    rem_q[0] <= rng_in ? CNT_W'(idx_in) : '0;
    quo_q[0] <= '0;
    idx_q[0] <= idx_in;
  end

  // --------------------------------------------------------------------------
  // Divider stages
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    cnt_t  rem_d;
    frac_t quo_d;

    always_comb begin
      step_t st;
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      for (int b = 0; b < STAGE_BITS; b++) begin
        st    = div_step(rem_d, cnt_q[s]);
        rem_d = st.rem;
        quo_d = {quo_d[FRAC_W-2:0], st.q};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rng_q[s+1] <= rng_q[s];
      cnt_q[s+1] <= cnt_q[s];
      rem_q[s+1] <= rem_d;
      quo_q[s+1] <= quo_d;
      idx_q[s+1] <= idx_q[s];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: radical inverse and zeroing of out-of-range beats
  // --------------------------------------------------------------------------
  radinv_t radinv_d;

  always_comb begin
    radinv_d = '0;
    for (int k = 0; k < IDX_W; k++) begin
      radinv_d[RADINV_W-1-k] = idx_q[DIV_STAGES][k];
    end
  end

  logic    done_q;
  frac_t   first_q;
  radinv_t second_q;
  logic    in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    in_range_q <= rng_q[DIV_STAGES];
    first_q    <= rng_q[DIV_STAGES] ? quo_q[DIV_STAGES] : '0;
    second_q   <= rng_q[DIV_STAGES] ? radinv_d : '0;
  end

  assign done_o         = done_q;
  assign first_coord_o  = first_q;
  assign second_coord_o = second_q;
  assign in_range_o     = in_range_q;

endmodule
